>>> src/ckns_pkg.sv
// Package with shared types and constants of the Chebyshev k-nearest-neighbor search core.
`default_nettype none
package ckns_pkg;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 16;
    localparam int FILL_W  = 6;

    localparam logic [1:0] CFG_POINT_COUNT    = 2'd0;
    localparam logic [1:0] CFG_DIMS_USED      = 2'd1;
    localparam logic [1:0] CFG_NEIGHBOR_COUNT = 2'd2;

    localparam logic [10:0] POINT_COUNT_RST    = 11'd1024;
    localparam logic [1:0]  DIMS_USED_RST      = 2'd3;
    localparam logic [5:0]  NEIGHBOR_COUNT_RST = 6'd4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [DIST_W-1:0] dist_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic pop;
    } list_ctrl_t;

endpackage
`default_nettype wire

>>> src/ckns_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ckns_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [$clog2(DEPTH)-1:0]          waddr,
    input  wire logic [WIDTH-1:0]                  wdata,
    input  wire logic [$clog2(DEPTH)-1:0]          raddr,
    output logic      [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> src/ckns_lane.sv
// One distance lane: registered absolute difference of one coordinate.
`default_nettype none
module ckns_lane (
    input  wire logic                                 clk,
    input  wire logic                                 enable,
    input  wire logic signed [ckns_pkg::COORD_W-1:0]  coord_p,
    input  wire logic signed [ckns_pkg::COORD_W-1:0]  coord_q,
    output ckns_pkg::dist_t                           abs_diff
);

    logic signed [ckns_pkg::COORD_W:0] diff;
    logic        [ckns_pkg::COORD_W:0] mag;

    always_comb
    begin
        diff = (ckns_pkg::COORD_W+1)'(coord_p) - (ckns_pkg::COORD_W+1)'(coord_q);
        mag  = diff[ckns_pkg::COORD_W] ? (ckns_pkg::COORD_W+1)'(-diff)
                                       : (ckns_pkg::COORD_W+1)'(diff);
    end

    always_ff @(posedge clk)
    begin
        abs_diff <= enable ? mag[ckns_pkg::DIST_W-1:0] : '0;
    end

endmodule
`default_nettype wire

>>> src/ckns_merge.sv
// Merging stage: registered maximum over the lane distances.
`default_nettype none
module ckns_merge #(
    parameter int LANES = 3
) (
    input  wire logic                  clk,
    input  wire ckns_pkg::dist_t       lane_dist [LANES],
    output ckns_pkg::dist_t            max_dist
);

    ckns_pkg::dist_t m;

    always_comb
    begin
        m = '0;
        for (int d = 0; d < LANES; d++)
        begin
            if (lane_dist[d] > m)
            begin
                m = lane_dist[d];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        max_dist <= m;
    end

endmodule
`default_nettype wire

>>> src/ckns_best_list.sv
// Sorted insertion list of the best neighbors, shifted out from the head.
`default_nettype none
module ckns_best_list #(
    parameter int DEPTH = 63,
    parameter int IW    = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ckns_pkg::list_ctrl_t              ctrl,
    input  wire logic [ckns_pkg::FILL_W-1:0]       limit,
    input  wire ckns_pkg::dist_t                   ins_dist,
    input  wire logic [IW-1:0]                     ins_idx,
    output ckns_pkg::dist_t                        head_dist,
    output logic      [IW-1:0]                     head_idx,
    output logic      [ckns_pkg::FILL_W-1:0]       fill
);

    ckns_pkg::dist_t             dist_reg [DEPTH];
    logic [IW-1:0]               idx_reg  [DEPTH];
    logic [ckns_pkg::FILL_W-1:0] fill_reg;
    logic [ckns_pkg::FILL_W-1:0] fill_next;
    logic [DEPTH-1:0]            keep;

    // An entry keeps its place when it is filled and not farther than the new one.
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            keep[j] = (32'(j) < 32'(fill_reg)) && (dist_reg[j] <= ins_dist);
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        priority if (ctrl.clear)
        begin
            fill_next = '0;
        end
        else if (ctrl.pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
        else if (ctrl.insert && fill_reg < limit)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            if (ctrl.pop)
            begin
                if (j < DEPTH - 1)
                begin
                    dist_reg[j] <= dist_reg[j+1];
                    idx_reg[j]  <= idx_reg[j+1];
                end
            end
            else if (ctrl.insert && !keep[j])
            begin
                if (j == 0 || keep[(j > 0) ? j-1 : 0])
                begin
                    dist_reg[j] <= ins_dist;
                    idx_reg[j]  <= ins_idx;
                end
                else
                begin
                    dist_reg[j] <= dist_reg[(j > 0) ? j-1 : 0];
                    idx_reg[j]  <= idx_reg[(j > 0) ? j-1 : 0];
                end
            end
        end
    end

    assign head_dist = dist_reg[0];
    assign head_idx  = idx_reg[0];
    assign fill      = fill_reg;

endmodule
`default_nettype wire

>>> src/chebyshev_knn_search_core.sv
// Top level of the Chebyshev k-nearest-neighbor search core.
// A load word is written when it is accepted. A query reads its point, scans the point
// set and drains the pipeline, then gives one result word per cycle unless out_ready stalls.
// Throughput: one query at a time, set by the single read port of the point store.
// Reset clears control state and sets the registers to point_count 1024,
// dims_used 3 and neighbor_count 4; the point store holds nothing until loaded.
`default_nettype none
module chebyshev_knn_search_core #(
    parameter int MAX_POINTS    = 1024,
    parameter int MAX_DIMS      = 3,
    parameter int MAX_NEIGHBORS = 63
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        operation,
    input  wire logic [9:0]  point_index,
    input  wire logic [15:0] coord_a,
    input  wire logic [15:0] coord_b,
    input  wire logic [15:0] coord_c,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [9:0]       neighbor_index,
    output logic [15:0]      neighbor_distance,
    output logic [5:0]       neighbor_rank,
    output logic             last_result,
    output logic             query_error
);

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int XW  = (AW > 10) ? AW : 10;
    localparam int SW  = MAX_DIMS * ckns_pkg::COORD_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_QREAD = 3'd1;
    localparam logic [2:0] ST_QWAIT = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_ERR   = 3'd6;

    // Configuration registers.
    logic [10:0] point_count_reg;
    logic [1:0]  dims_used_reg;
    logic [5:0]  neighbor_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg    <= ckns_pkg::POINT_COUNT_RST;
            dims_used_reg      <= ckns_pkg::DIMS_USED_RST;
            neighbor_count_reg <= ckns_pkg::NEIGHBOR_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ckns_pkg::CFG_POINT_COUNT:    point_count_reg    <= cfg_data;
                ckns_pkg::CFG_DIMS_USED:      dims_used_reg      <= cfg_data[1:0];
                ckns_pkg::CFG_NEIGHBOR_COUNT: neighbor_count_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Effective point count and number of dimensions, clamped to the build limits.
    logic [CW-1:0] n_eff;
    logic [3:0]    dims_eff;

    always_comb
    begin
        if (32'(point_count_reg) > MAX_POINTS)
        begin
            n_eff = CW'(MAX_POINTS);
        end
        else
        begin
            n_eff = CW'(point_count_reg);
        end
        if (dims_used_reg == 2'd0)
        begin
            dims_eff = 4'd1;
        end
        else if (32'(dims_used_reg) > MAX_DIMS)
        begin
            dims_eff = 4'(MAX_DIMS);
        end
        else
        begin
            dims_eff = 4'(dims_used_reg);
        end
    end

    // Control state.
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] scan_reg,  scan_next;
    logic [1:0]    drain_reg, drain_next;
    logic [9:0]    pi_reg;
    logic [5:0]    rank_reg,  rank_next;
    logic          t1_reg, t2_reg, t3_reg;
    logic [AW-1:0] t1_idx_reg, t2_idx_reg, t3_idx_reg;

    logic in_fire;
    logic out_free;
    logic query_bad;
    logic scan_last;

    ckns_pkg::list_ctrl_t      list_ctrl;
    ckns_pkg::dist_t           head_dist;
    logic [AW-1:0]             head_idx;
    logic [ckns_pkg::FILL_W-1:0] list_fill;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid || out_ready;

    // A query is refused when the index is outside the point set or the neighbor count is
    // zero, exceeds the list depth, or cannot be met from the other points.
    assign query_bad = (32'(point_index) >= 32'(n_eff)) || (neighbor_count_reg == 6'd0)
                    || (32'(neighbor_count_reg) > MAX_NEIGHBORS)
                    || (32'(neighbor_count_reg) >= 32'(n_eff));

    assign scan_last = (32'(scan_reg) + 32'd1 == 32'(n_eff));

    always_comb
    begin
        state_next       = state_reg;
        scan_next        = scan_reg;
        drain_next       = drain_reg;
        rank_next        = rank_reg;
        list_ctrl.clear  = 1'b0;
        list_ctrl.pop    = 1'b0;
        list_ctrl.insert = t3_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && operation == ckns_pkg::OP_QUERY)
                begin
                    state_next = query_bad ? ST_ERR : ST_QREAD;
                end
            end
            ST_QREAD:
            begin
                state_next      = ST_QWAIT;
                list_ctrl.clear = 1'b1;
            end
            ST_QWAIT:
            begin
                state_next = ST_SCAN;
                scan_next  = '0;
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                    drain_next = '0;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2)
                begin
                    state_next = ST_EMIT;
                    rank_next  = '0;
                end
            end
            ST_EMIT:
            begin
                list_ctrl.insert = 1'b0;
                if (out_free)
                begin
                    list_ctrl.pop = 1'b1;
                    rank_next     = rank_reg + 1'b1;
                    if (list_fill == 6'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
            drain_reg <= '0;
            rank_reg  <= '0;
            t1_reg    <= 1'b0;
            t2_reg    <= 1'b0;
            t3_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            drain_reg <= drain_next;
            rank_reg  <= rank_next;
            // The queried point itself never enters the list.
            t1_reg    <= (state_reg == ST_SCAN) && (scan_reg != CW'(pi_reg));
            t2_reg    <= t1_reg;
            t3_reg    <= t2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pi_reg <= point_index;
        end
        t1_idx_reg <= scan_reg[AW-1:0];
        t2_idx_reg <= t1_idx_reg;
        t3_idx_reg <= t2_idx_reg;
    end

    // Point store: loads write it, the query point and the scan read it.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [XW-1:0] pi_wide;
    logic [XW-1:0] in_idx_wide;
    logic [SW-1:0] ram_wdata;
    logic [SW-1:0] ram_rdata;
    logic [SW-1:0] q_reg;

    assign in_idx_wide = XW'(point_index);
    assign pi_wide     = XW'(pi_reg);
    assign ram_we      = in_fire && (operation == ckns_pkg::OP_LOAD)
                      && (32'(point_index) < MAX_POINTS);
    assign ram_waddr   = in_idx_wide[AW-1:0];
    assign ram_raddr   = (state_reg == ST_QREAD) ? pi_wide[AW-1:0] : scan_reg[AW-1:0];

    // Coordinates beyond the third are stored as zero.
    always_comb
    begin
        ram_wdata = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (d == 0)
            begin
                ram_wdata[d*ckns_pkg::COORD_W +: ckns_pkg::COORD_W] = coord_a;
            end
            else if (d == 1)
            begin
                ram_wdata[d*ckns_pkg::COORD_W +: ckns_pkg::COORD_W] = coord_b;
            end
            else if (d == 2)
            begin
                ram_wdata[d*ckns_pkg::COORD_W +: ckns_pkg::COORD_W] = coord_c;
            end
        end
    end

    ckns_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_QWAIT)
        begin
            q_reg <= ram_rdata;
        end
    end

    // One lane per coordinate, then the maximum over the lanes in use.
    ckns_pkg::dist_t lane_dist [MAX_DIMS];
    ckns_pkg::dist_t cand_dist;

    for (genvar g = 0; g < MAX_DIMS; g++)
    begin : g_lane
        ckns_lane u_lane (
            .clk      (clk),
            .enable   (32'(g) < 32'(dims_eff)),
            .coord_p  (ram_rdata[g*ckns_pkg::COORD_W +: ckns_pkg::COORD_W]),
            .coord_q  (q_reg[g*ckns_pkg::COORD_W +: ckns_pkg::COORD_W]),
            .abs_diff (lane_dist[g])
        );
    end

    ckns_merge #(
        .LANES (MAX_DIMS)
    ) u_merge (
        .clk       (clk),
        .lane_dist (lane_dist),
        .max_dist  (cand_dist)
    );

    ckns_best_list #(
        .DEPTH (MAX_NEIGHBORS),
        .IW    (AW)
    ) u_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (list_ctrl),
        .limit     (neighbor_count_reg),
        .ins_dist  (cand_dist),
        .ins_idx   (t3_idx_reg),
        .head_dist (head_dist),
        .head_idx  (head_idx),
        .fill      (list_fill)
    );

    // Output word register; it lets the block take new words while a result waits.
    logic          out_valid_reg;
    logic [XW-1:0] head_idx_wide;

    assign head_idx_wide = XW'(head_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= (state_reg == ST_EMIT) || (state_reg == ST_ERR);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (state_reg == ST_ERR)
            begin
                neighbor_index    <= '0;
                neighbor_distance <= '0;
                neighbor_rank     <= '0;
                last_result       <= 1'b1;
                query_error       <= 1'b1;
            end
            else
            begin
                neighbor_index    <= head_idx_wide[9:0];
                neighbor_distance <= head_dist;
                neighbor_rank     <= rank_reg;
                last_result       <= (list_fill == 6'd1);
                query_error       <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire
